// File: rtl/core/mte_pkg.sv
`default_nettype none
package mte_pkg;
  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned TotalBitsDef = 48;
  localparam int unsigned RateBits = 24;
  localparam int unsigned OutBits = 48;
  localparam int unsigned FracBits = 16;
  localparam int unsigned KindBits = 3;
  localparam logic [RateBits-1:0] RapidRateReset = 24'd5000000;

  typedef enum logic [KindBits-1:0] {
    KIND_RAPID  = 3'd0,
    KIND_LINEAR = 3'd1,
    KIND_ARC_CW = 3'd2,
    KIND_ARC_CCW = 3'd3,
    KIND_DWELL  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } back_state_e;
endpackage
`default_nettype wire

// File: rtl/core/mte_front.sv
`default_nettype none
// Takes an item, picks its rate and forms the squared length.
module mte_front #(
  parameter int unsigned CoordBits = mte_pkg::CoordBitsDef,
  parameter int unsigned SqBits = 2 * CoordBits + 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [mte_pkg::KindBits-1:0]  kind_i,
  input  wire logic signed [CoordBits-1:0]   start_x_i,
  input  wire logic signed [CoordBits-1:0]   start_y_i,
  input  wire logic signed [CoordBits-1:0]   start_z_i,
  input  wire logic signed [CoordBits-1:0]   end_x_i,
  input  wire logic signed [CoordBits-1:0]   end_y_i,
  input  wire logic signed [CoordBits-1:0]   end_z_i,
  input  wire logic [mte_pkg::RateBits-1:0]  feed_i,
  input  wire logic                          last_segment_i,
  input  wire logic [mte_pkg::RateBits-1:0]  rapid_rate_i,
  output logic                               q_valid_o,
  input  wire logic                          q_take_i,
  output logic [SqBits-1:0]                  q_sq_o,
  output logic [mte_pkg::RateBits-1:0]       q_rate_o,
  output logic                               q_last_o
);
  import mte_pkg::*;
  localparam int unsigned DBits = CoordBits + 1;

  // Stage 1 registers absolute differences; stage 2 holds the queue entry.
  logic              s1_valid_q;
  logic [DBits-1:0]  dx_q, dy_q, dz_q;
  logic [RateBits-1:0] rate1_q;
  logic              last1_q;
  logic              s2_valid_q;
  logic [SqBits-1:0] sq_q;
  logic [RateBits-1:0] rate2_q;
  logic              last2_q;

  logic s2_free, s1_free;
  logic signed [DBits-1:0] ddx, ddy, ddz;
  logic [2*DBits-1:0] px, py, pz;

  assign s2_free = !s2_valid_q || q_take_i;
  assign s1_free = !s1_valid_q || s2_free;
  assign full_o  = !s1_free;

  function automatic logic [DBits-1:0] absd(input logic signed [DBits-1:0] d);
    absd = d[DBits-1] ? DBits'(-d) : DBits'(d);
  endfunction

  assign ddx = DBits'(end_x_i) - DBits'(start_x_i);
  assign ddy = DBits'(end_y_i) - DBits'(start_y_i);
  assign ddz = DBits'(end_z_i) - DBits'(start_z_i);
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) s1_valid_q <= push_i;
      if (s2_free) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && push_i) begin
      dx_q    <= absd(ddx);
      dy_q    <= absd(ddy);
      dz_q    <= absd(ddz);
      rate1_q <= (kind_i == KIND_RAPID) ? rapid_rate_i : feed_i;
      last1_q <= last_segment_i;
    end
    if (s2_free && s1_valid_q) begin
      sq_q    <= SqBits'(px) + SqBits'(py) + SqBits'(pz);
      rate2_q <= rate1_q;
      last2_q <= last1_q;
    end
  end

  assign q_valid_o = s2_valid_q;
  assign q_sq_o    = sq_q;
  assign q_rate_o  = rate2_q;
  assign q_last_o  = last2_q;
endmodule
`default_nettype wire

// File: rtl/core/mte_back.sv
`default_nettype none
// Root, divide and accumulate, one bit per cycle, with a one-entry result buffer.
module mte_back #(
  parameter int unsigned CoordBits = mte_pkg::CoordBitsDef,
  parameter int unsigned TotalBits = mte_pkg::TotalBitsDef,
  parameter int unsigned SqBits = 2 * CoordBits + 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  output logic                              q_take_o,
  input  wire logic [SqBits-1:0]            q_sq_i,
  input  wire logic [mte_pkg::RateBits-1:0] q_rate_i,
  input  wire logic                         q_last_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [mte_pkg::OutBits-1:0]       total_time_o,
  output logic [mte_pkg::OutBits-1:0]       segment_time_o,
  output logic                              path_done_o,
  output logic                              saturated_o
);
  import mte_pkg::*;
  localparam int unsigned RootBits = SqBits / 2;
  localparam int unsigned NumBits = RootBits + FracBits;
  localparam int unsigned RemBits = RateBits + 1;
  localparam int unsigned CntBits = $clog2(NumBits + 1);
  localparam int unsigned SumBits = ((TotalBits > NumBits) ? TotalBits : NumBits) + 1;
  localparam logic [TotalBits-1:0] TotalMax = '1;

  back_state_e state_q, state_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [SqBits-1:0]   rad_q, rad_d;
  logic [RootBits+1:0] rem_s_q, rem_s_d;
  logic [RootBits-1:0] root_q, root_d;
  logic [NumBits-1:0]  quo_q, quo_d;
  logic [RemBits-1:0]  rem_q, rem_d;
  logic [RateBits-1:0] rate_q, rate_d;
  logic                last_q, last_d;
  logic [TotalBits-1:0] total_q, total_d;
  logic                clip_q, clip_d;
  logic                ov_q, ov_d;
  logic [OutBits-1:0]  o_tot_q, o_tot_d, o_seg_q, o_seg_d;
  logic                o_done_q, o_done_d, o_sat_q, o_sat_d;

  logic [RootBits+1:0] trial_s, rs_sh;
  logic [RemBits-1:0]  rem_sh;
  logic [SumBits-1:0]  sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      total_q  <= '0;
      clip_q   <= 1'b0;
      empty_o  <= 1'b1;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      clip_q   <= clip_d;
      cnt_q    <= cnt_d;
      if (state_q == ST_OUT && state_d == ST_IDLE) empty_o <= 1'b0;
      else if (pop_i) empty_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d; rem_s_q <= rem_s_d; root_q <= root_d;
    quo_q <= quo_d; rem_q <= rem_d; rate_q <= rate_d; last_q <= last_d;
    ov_q <= ov_d;
    o_tot_q <= o_tot_d; o_seg_q <= o_seg_d; o_done_q <= o_done_d; o_sat_q <= o_sat_d;
  end

  // Restoring root: two radicand bits per step.
  assign rs_sh   = {rem_s_q[RootBits-1:0], rad_q[SqBits-1 -: 2]};
  assign trial_s = {root_q, 2'b01};
  // Restoring divide of (root << 16) by rate, numerator bits come from quo_q.
  assign rem_sh  = {rem_q[RemBits-2:0], quo_q[NumBits-1]};
  assign sum     = SumBits'(total_q) + SumBits'(quo_q);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q;
    rad_d = rad_q; rem_s_d = rem_s_q; root_d = root_q;
    quo_d = quo_q; rem_d = rem_q; rate_d = rate_q; last_d = last_q;
    total_d = total_q; clip_d = clip_q; ov_d = ov_q;
    o_tot_d = o_tot_q; o_seg_d = o_seg_q; o_done_d = o_done_q; o_sat_d = o_sat_q;
    q_take_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && (empty_o || pop_i)) begin
          q_take_o = 1'b1;
          rad_d = q_sq_i; rem_s_d = '0; root_d = '0;
          rate_d = q_rate_i; last_d = q_last_i;
          cnt_d = CntBits'(RootBits);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rad_d = rad_q << 2;
        if (rs_sh >= trial_s) begin
          rem_s_d = rs_sh - trial_s;
          root_d  = {root_q[RootBits-2:0], 1'b1};
        end else begin
          rem_s_d = rs_sh;
          root_d  = {root_q[RootBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          quo_d = {root_d, FracBits'(0)};
          rem_d = '0;
          cnt_d = CntBits'(NumBits);
          state_d = (rate_q == '0) ? ST_ACC : ST_DIV;
          if (rate_q == '0) quo_d = '0;
        end
      end
      ST_DIV: begin
        if (rem_sh >= RemBits'(rate_q)) begin
          rem_d = rem_sh - RemBits'(rate_q);
          quo_d = {quo_q[NumBits-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[NumBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) state_d = ST_ACC;
      end
      ST_ACC: begin
        ov_d = |sum[SumBits-1:TotalBits];
        total_d = sum[TotalBits-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (ov_q) begin
          total_d = TotalMax;
        end
        o_tot_d  = OutBits'(total_d);
        o_seg_d  = OutBits'(quo_q);
        o_done_d = last_q;
        o_sat_d  = clip_q || ov_q;
        clip_d   = clip_q || ov_q;
        if (last_q) begin
          total_d = '0;
          clip_d  = 1'b0;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign total_time_o   = o_tot_q;
  assign segment_time_o = o_seg_q;
  assign path_done_o    = o_done_q;
  assign saturated_o    = o_sat_q;
endmodule
`default_nettype wire

// File: rtl/core/motion_time_estimator_top.sv
`default_nettype none
// Channel  | ports                                   | handshake
// input    | kind_i .. last_segment_i                | push, full
// result   | total_time_o .. saturated_o             | empty, pop
// config   | rapid_rate_i                            | cfg_we_i
// An item passes through the front pipeline stages. The back unit then picks it up,
// runs the bit-serial root and the bit-serial divide, then accumulates and registers
// the output; it takes no new item until it is idle and the result buffer is empty or popped.
// Reset clears the total, the saturation flag and all valid state; rapid_rate returns to 5000000.
// A result not popped holds the back unit, and the front then fills and stalls.
module motion_time_estimator_top #(
  parameter int unsigned COORD_BITS = mte_pkg::CoordBitsDef,
  parameter int unsigned TOTAL_BITS = mte_pkg::TotalBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mte_pkg::RateBits-1:0]  rapid_rate_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [mte_pkg::KindBits-1:0]  kind_i,
  input  wire logic signed [COORD_BITS-1:0]  start_x_i,
  input  wire logic signed [COORD_BITS-1:0]  start_y_i,
  input  wire logic signed [COORD_BITS-1:0]  start_z_i,
  input  wire logic signed [COORD_BITS-1:0]  end_x_i,
  input  wire logic signed [COORD_BITS-1:0]  end_y_i,
  input  wire logic signed [COORD_BITS-1:0]  end_z_i,
  input  wire logic [mte_pkg::RateBits-1:0]  feed_i,
  input  wire logic                          last_segment_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [mte_pkg::OutBits-1:0]        total_time_o,
  output logic [mte_pkg::OutBits-1:0]        segment_time_o,
  output logic                               path_done_o,
  output logic                               saturated_o
);
  import mte_pkg::*;
  localparam int unsigned SqBits = 2 * COORD_BITS + 4;

  logic [RateBits-1:0] rapid_q;
  logic q_valid, q_take, q_last;
  logic [SqBits-1:0] q_sq;
  logic [RateBits-1:0] q_rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rapid_q <= RapidRateReset;
    end else if (cfg_we_i) begin
      rapid_q <= rapid_rate_i;
    end
  end

  mte_front #(.CoordBits(COORD_BITS), .SqBits(SqBits)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .kind_i, .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .feed_i, .last_segment_i, .rapid_rate_i(rapid_q),
    .q_valid_o(q_valid), .q_take_i(q_take), .q_sq_o(q_sq), .q_rate_o(q_rate),
    .q_last_o(q_last)
  );

  mte_back #(.CoordBits(COORD_BITS), .TotalBits(TOTAL_BITS), .SqBits(SqBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_take_o(q_take), .q_sq_i(q_sq),
    .q_rate_i(q_rate), .q_last_i(q_last), .empty_o(empty), .pop_i(pop),
    .total_time_o, .segment_time_o, .path_done_o, .saturated_o
  );
endmodule
`default_nettype wire
